### rtl/cmtr_pkg.sv
// Shared types and constants for the click mode / turnout restore block.
package cmtr_pkg;

  localparam int MAX_TURNOUTS  = 32;
  localparam int TIME_BITS_DEF = 32;

  localparam int CNT_W  = 6;
  localparam int MASK_W = 32;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  localparam logic [CNT_W-1:0] CNT_LIMIT =
    (MAX_TURNOUTS > 63) ? CNT_W'(63) : CNT_W'(MAX_TURNOUTS);

  localparam logic [15:0] STEP_RST  = 16'd600;
  localparam logic [9:0]  MINP_RST  = 10'd20;
  localparam logic [11:0] MAXP_RST  = 12'd400;
  localparam logic [11:0] GAP_RST   = 12'd300;
  localparam logic [11:0] BLINK_RST = 12'd200;

  localparam logic MODE_AUTO   = 1'b0;
  localparam logic MODE_MANUAL = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_TURNOUT_COUNT,
    REG_HOME_POS,
    REG_SAVED_POS,
    REG_STEP_INTERVAL,
    REG_MIN_PRESS,
    REG_MAX_PRESS,
    REG_CLICK_GAP,
    REG_BLINK_PERIOD
  } reg_idx_t;

  typedef enum logic [1:0] {
    DONE_NONE,
    DONE_HOME,
    DONE_SAVED
  } done_t;

  typedef struct packed {
    logic [CNT_W-1:0]  turnout_count;
    logic [MASK_W-1:0] home_positions;
    logic [MASK_W-1:0] saved_positions;
    logic [15:0]       step_interval;
    logic [9:0]        min_press;
    logic [11:0]       max_press;
    logic [11:0]       click_gap;
    logic [11:0]       blink_period;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic home;
    logic mode;
    logic mode_ev;
  } click_act_t;

endpackage

### rtl/cmtr_cfg.sv
// Configuration register file.
module cmtr_cfg
  import cmtr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  output cfg_t              cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.turnout_count   <= '0;
      cfg_r.home_positions  <= '0;
      cfg_r.saved_positions <= '0;
      cfg_r.step_interval   <= STEP_RST;
      cfg_r.min_press       <= MINP_RST;
      cfg_r.max_press       <= MAXP_RST;
      cfg_r.click_gap       <= GAP_RST;
      cfg_r.blink_period    <= BLINK_RST;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_TURNOUT_COUNT: cfg_r.turnout_count   <= cfg_data[CNT_W-1:0];
        REG_HOME_POS:      cfg_r.home_positions  <= cfg_data[MASK_W-1:0];
        REG_SAVED_POS:     cfg_r.saved_positions <= cfg_data[MASK_W-1:0];
        REG_STEP_INTERVAL: cfg_r.step_interval   <= cfg_data[15:0];
        REG_MIN_PRESS:     cfg_r.min_press       <= cfg_data[9:0];
        REG_MAX_PRESS:     cfg_r.max_press       <= cfg_data[11:0];
        REG_CLICK_GAP:     cfg_r.click_gap       <= cfg_data[11:0];
        REG_BLINK_PERIOD:  cfg_r.blink_period    <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/cmtr_click.sv
// Tick counter, button edge timing, click counting and mode decisions.
module cmtr_click
  import cmtr_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 button_level,
  input  cfg_t                 cfg,
  output logic [TIME_BITS-1:0] now,
  output click_act_t           act
);

  logic [TIME_BITS-1:0] now_r, press_r, release_r;
  logic [1:0]           tally_r, tally_mid, tally_nxt;
  logic                 prev_r, mode_r;
  logic                 press_edge, rel_edge, good, fire;
  logic [TIME_BITS-1:0] press_dt, gap_dt;

  always_comb begin
    press_edge = prev_r & ~button_level;
    rel_edge   = ~prev_r & button_level;
    press_dt   = now_r - press_r;
    gap_dt     = now_r - release_r;
    good       = (press_dt > TIME_BITS'(cfg.min_press)) &&
                 (press_dt < TIME_BITS'(cfg.max_press));
    tally_mid  = (rel_edge && good && tally_r != 2'd3) ? tally_r + 2'd1 : tally_r;
    // a release this tick leaves a zero gap, which never ends the group
    fire       = (tally_mid != 2'd0) && !rel_edge && (gap_dt > TIME_BITS'(cfg.click_gap));
    tally_nxt  = fire ? 2'd0 : tally_mid;

    act.mode_ev = fire && (tally_mid == 2'd1 || tally_mid == 2'd2);
    act.start   = fire && (tally_mid == 2'd2 || (tally_mid == 2'd1 && mode_r == MODE_MANUAL));
    act.home    = (tally_mid == 2'd1);
    act.mode    = act.mode_ev ? ((tally_mid == 2'd1) ? ~mode_r : MODE_AUTO) : mode_r;
  end

  assign now = now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r     <= TIME_BITS'(1);
      press_r   <= '0;
      release_r <= '0;
      tally_r   <= '0;
      prev_r    <= 1'b1;
      mode_r    <= MODE_AUTO;
    end else if (en) begin
      now_r   <= now_r + TIME_BITS'(1);
      tally_r <= tally_nxt;
      prev_r  <= button_level;
      mode_r  <= act.mode;
      if (press_edge) begin
        press_r <= now_r;
      end
      if (rel_edge) begin
        release_r <= now_r;
      end
    end
  end

endmodule

### rtl/cmtr_restore.sv
// LED blinking and the sequential turnout restore.
module cmtr_restore
  import cmtr_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  cfg_t                 cfg,
  input  logic [TIME_BITS-1:0] now,
  input  click_act_t           act,
  output logic                 led_auto,
  output done_t                done_event,
  output logic                 switch_valid,
  output logic [4:0]           switch_index,
  output logic                 switch_direction
);

  logic                 blink_on_r, phase_r, auto_led_r, active_r, home_r;
  logic [TIME_BITS-1:0] blink_time_r, due_r;
  logic [CNT_W-1:0]     idx_r;

  logic                 phase_e, toggle, phase_nxt, led_mid;
  logic                 active_e, home_e, step, finish, cmd;
  logic [CNT_W-1:0]     idx_e, count;
  logic [TIME_BITS-1:0] blink_dt;
  logic [MASK_W-1:0]    mask;

  always_comb begin
    phase_e   = act.start ? 1'b0 : phase_r;
    blink_dt  = now - blink_time_r;
    toggle    = act.start ? (cfg.blink_period == 12'd0)
                          : (blink_on_r && blink_dt >= TIME_BITS'(cfg.blink_period));
    phase_nxt = toggle ? ~phase_e : phase_e;
    led_mid   = act.mode_ev ? (act.mode == MODE_AUTO) : auto_led_r;

    active_e  = act.start | active_r;
    home_e    = act.start ? act.home : home_r;
    idx_e     = act.start ? '0 : idx_r;
    step      = active_e && (act.start || now >= due_r);
    count     = (cfg.turnout_count > CNT_LIMIT) ? CNT_LIMIT : cfg.turnout_count;
    finish    = step && (idx_e >= count);
    cmd       = step && !finish;
    mask      = home_e ? cfg.home_positions : cfg.saved_positions;

    if (finish) begin
      led_auto = (act.mode == MODE_AUTO);
    end else if (toggle) begin
      led_auto = phase_nxt;
    end else begin
      led_auto = led_mid;
    end
    done_event       = finish ? (home_e ? DONE_HOME : DONE_SAVED) : DONE_NONE;
    switch_valid     = cmd;
    switch_index     = cmd ? idx_e[4:0] : 5'd0;
    switch_direction = cmd && !idx_e[CNT_W-1] && mask[idx_e[4:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_on_r   <= 1'b0;
      phase_r      <= 1'b0;
      auto_led_r   <= 1'b1;
      active_r     <= 1'b0;
      home_r       <= 1'b1;
      idx_r        <= '0;
      blink_time_r <= '0;
      due_r        <= '0;
    end else if (en) begin
      blink_on_r <= active_e & ~finish;
      active_r   <= active_e & ~finish;
      phase_r    <= phase_nxt;
      auto_led_r <= led_auto;
      home_r     <= home_e;
      idx_r      <= cmd ? idx_e + CNT_W'(1) : idx_e;
      if (act.start || toggle) begin
        blink_time_r <= now;
      end
      if (cmd) begin
        due_r <= now + TIME_BITS'(cfg.step_interval);
      end else if (act.start) begin
        due_r <= '0;
      end
    end
  end

  a_blink_tracks_restore: assert property (@(posedge clk) disable iff (!rst_n)
    blink_on_r == active_r)
    else $error("blink enable out of step with restore");

  a_start_acts_now: assert property (@(posedge clk) disable iff (!rst_n)
    en && act.start |-> switch_valid || done_event != DONE_NONE)
    else $error("restore start without first step");

  a_cmd_keeps_active: assert property (@(posedge clk) disable iff (!rst_n)
    en && switch_valid |=> active_r)
    else $error("restore dropped after a command");

  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    en && done_event != DONE_NONE |=> !active_r)
    else $error("restore still active after done");

  a_idle_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r && !act.start |-> !switch_valid && done_event == DONE_NONE)
    else $error("command issued with no restore running");

endmodule

### rtl/click_mode_turnout_restore_top.sv
// Top level: stream handshake, input and result registers, submodule wiring.
//
// Push-button mode selector with sequential turnout restore.
// in_*  : one transaction per 1 ms tick, in_tdata[0] = sampled button (0 pressed).
// out_* : exactly one result transaction per input transaction, in order.
// cfg_* : register writes (index, data); cfg_ready is always high. Write only
//         while no transaction is in flight.
// The input register loads at the edge that takes the transaction, and the result
// register loads from it once the output can advance; out_tvalid then rises.
// Throughput: one transaction per cycle while out_tready is high; the whole
// tick update is one pass of logic between the input and result registers.
// Stall: when out_tready is low the result register holds, the input register
// fills, and in_tready drops only when both are occupied.
// Reset (rst_n low, synchronous): registers go to their defaults, automatic
// mode, auto LED on, no restore running, tick time one.
module click_mode_turnout_restore_top
  import cmtr_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [0] button_level
  output logic              out_tvalid,
  input  logic              out_tready,
  // [0] mode, [1] led_auto, [2] led_manual, [3] mode_event, [5:4] done_event,
  // [6] switch_valid, [11:7] switch_index, [12] switch_direction
  output logic [15:0]       out_tdata,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  cfg_t                 cfg;
  click_act_t           act;
  logic [TIME_BITS-1:0] now;
  logic                 s1_valid_r, s1_level_r, out_valid_r;
  logic [15:0]          out_data_r;
  logic                 adv, en;
  logic                 led_auto, sw_valid, sw_dir;
  done_t                done_event;
  logic [4:0]           sw_index;

  assign adv       = !out_valid_r || out_tready;
  assign en        = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;

  cmtr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cmtr_click #(.TIME_BITS(TIME_BITS)) u_click (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .button_level (s1_level_r),
    .cfg          (cfg),
    .now          (now),
    .act          (act)
  );

  cmtr_restore #(.TIME_BITS(TIME_BITS)) u_restore (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (en),
    .cfg              (cfg),
    .now              (now),
    .act              (act),
    .led_auto         (led_auto),
    .done_event       (done_event),
    .switch_valid     (sw_valid),
    .switch_index     (sw_index),
    .switch_direction (sw_dir)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (en) begin
        s1_valid_r <= 1'b0;
      end
      if (en) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_level_r <= in_tdata[0];
    end
    if (en) begin
      out_data_r <= {3'b000, sw_dir, sw_index, sw_valid, done_event,
                     act.mode_ev, act.mode, led_auto, act.mode};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### tb/sv/click_mode_turnout_restore_checker.sv
// Checker that predicts every tick result of the button mode selector and compares it.
`timescale 1ns / 1ps
module click_mode_turnout_restore_checker
  import cmtr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [7:0]        in_tdata,   // [0] button_level
  input  logic              out_tvalid,
  input  logic              out_tready,
  // [0] mode, [1] led_auto, [2] led_manual, [3] mode_event, [5:4] done_event,
  // [6] switch_valid, [11:7] switch_index, [12] switch_direction
  input  logic [15:0]       out_tdata,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  reg_idx_t          cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  output int                mismatches,
  output int                in_flight
);

  typedef struct packed {
    logic       mode;
    logic       led_auto;
    logic       led_manual;
    logic       mode_ev;
    done_t      done;
    logic       sw_valid;
    logic [4:0] sw_index;
    logic       sw_dir;
  } tick_outputs_t;

  tick_outputs_t outputs_due[$];
  cfg_t          regs;

  logic [31:0] ms_now, press_at, release_at, blink_at, next_step_at;
  logic        mode_q, led_auto_q, led_man_q, last_level, mode_changed;
  logic [1:0]  clicks;
  logic        blinking, blink_ph, restoring, restore_to_home;
  logic [5:0]  next_turnout;

  function automatic void select_mode(input logic m);
    mode_q       = m;
    led_auto_q   = (m == MODE_AUTO);
    led_man_q    = (m == MODE_MANUAL);
    mode_changed = 1'b1;
  endfunction

  function automatic void begin_restore(input logic home, input logic [31:0] now);
    restoring       = 1'b1;
    restore_to_home = home;
    next_turnout    = '0;
    next_step_at    = '0;
    blinking        = 1'b1;
    blink_at        = now;
    blink_ph        = 1'b0;
  endfunction

  task automatic compute_tick_outputs(input logic level, output tick_outputs_t r);
    logic [31:0] now;
    logic [31:0] held;
    logic [31:0] dirs;
    logic [5:0]  limit;
    r = '0;
    r.done = DONE_NONE;
    mode_changed = 1'b0;
    ms_now = ms_now + 32'd1;
    now = ms_now;

    if (last_level && !level) press_at = now;
    if (!last_level && level) begin
      held = now - press_at;
      if (held > 32'(regs.min_press) && held < 32'(regs.max_press) && clicks < 2'd3)
        clicks = clicks + 2'd1;
      release_at = now;
    end
    if (clicks != 2'd0 && (now - release_at) > 32'(regs.click_gap)) begin
      if (clicks == 2'd1) begin
        if (mode_q == MODE_AUTO) begin
          select_mode(MODE_MANUAL);
        end else begin
          select_mode(MODE_AUTO);
          begin_restore(1'b1, now);
        end
      end else if (clicks == 2'd2) begin
        select_mode(MODE_AUTO);
        begin_restore(1'b0, now);
      end
      clicks = 2'd0;
    end
    last_level = level;

    if (blinking && (now - blink_at) >= 32'(regs.blink_period)) begin
      blink_at   = now;
      blink_ph   = ~blink_ph;
      led_auto_q = blink_ph;
    end

    if (restoring && now >= next_step_at) begin
      limit = (regs.turnout_count > MAX_TURNOUTS) ? 6'(MAX_TURNOUTS) : regs.turnout_count;
      if (next_turnout >= limit) begin
        restoring  = 1'b0;
        blinking   = 1'b0;
        led_auto_q = (mode_q == MODE_AUTO);
        r.done     = restore_to_home ? DONE_HOME : DONE_SAVED;
      end else begin
        dirs         = restore_to_home ? regs.home_positions : regs.saved_positions;
        r.sw_valid   = 1'b1;
        r.sw_index   = next_turnout[4:0];
        r.sw_dir     = (next_turnout < 6'd32) ? dirs[next_turnout[4:0]] : 1'b0;
        next_turnout = next_turnout + 6'd1;
        next_step_at = now + 32'(regs.step_interval);
      end
    end

    r.mode       = mode_q;
    r.led_auto   = led_auto_q;
    r.led_manual = led_man_q;
    r.mode_ev    = mode_changed;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    tick_outputs_t want;
    if (!rst_n) begin
      regs               = '0;
      regs.step_interval = STEP_RST;
      regs.min_press     = MINP_RST;
      regs.max_press     = MAXP_RST;
      regs.click_gap     = GAP_RST;
      regs.blink_period  = BLINK_RST;
      ms_now = '0; press_at = '0; release_at = '0; blink_at = '0; next_step_at = '0;
      mode_q = MODE_AUTO; led_auto_q = 1'b1; led_man_q = 1'b0; last_level = 1'b1;
      clicks = '0; blinking = 1'b0; blink_ph = 1'b0; restoring = 1'b0;
      restore_to_home = 1'b1; next_turnout = '0; mode_changed = 1'b0;
      outputs_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TURNOUT_COUNT: regs.turnout_count   = cfg_data[5:0];
          REG_HOME_POS:      regs.home_positions  = cfg_data;
          REG_SAVED_POS:     regs.saved_positions = cfg_data;
          REG_STEP_INTERVAL: regs.step_interval   = cfg_data[15:0];
          REG_MIN_PRESS:     regs.min_press       = cfg_data[9:0];
          REG_MAX_PRESS:     regs.max_press       = cfg_data[11:0];
          REG_CLICK_GAP:     regs.click_gap       = cfg_data[11:0];
          REG_BLINK_PERIOD:  regs.blink_period    = cfg_data[11:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        compute_tick_outputs(in_tdata[0], want);
        outputs_due.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        if (outputs_due.size() == 0) begin
          $error("result transaction with no tick outstanding: %h", out_tdata);
          mismatches++;
        end else begin
          want = outputs_due.pop_front();
          check_field("mode",             want.mode,       out_tdata[0]);
          check_field("led_auto",         want.led_auto,   out_tdata[1]);
          check_field("led_manual",       want.led_manual, out_tdata[2]);
          check_field("mode_event",       want.mode_ev,    out_tdata[3]);
          check_field("done_event",       int'(want.done), int'(out_tdata[5:4]));
          check_field("switch_valid",     want.sw_valid,   out_tdata[6]);
          check_field("switch_index",     want.sw_index,   out_tdata[11:7]);
          check_field("switch_direction", want.sw_dir,     out_tdata[12]);
        end
      end
    end
    in_flight <= outputs_due.size();
  end

endmodule

### tb/sv/click_mode_turnout_restore_top_test.sv
// Stimulus and verdict for the click mode / turnout restore block.
`timescale 1ns / 1ps
module click_mode_turnout_restore_top_test;
  import cmtr_pkg::*;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = 8'd0;   // [0] button_level
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // [0] mode, [1] led_auto, [2] led_manual, [3] mode_event, [5:4] done_event,
  // [6] switch_valid, [11:7] switch_index, [12] switch_direction
  logic [15:0]       out_tdata;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  reg_idx_t          cfg_index  = REG_TURNOUT_COUNT;
  logic [DATA_W-1:0] cfg_data   = '0;

  int   mismatches;
  int   in_flight;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   ticks_sent     = 0;
  cfg_t cur_cfg;

  // tick i of the directed run is bit i, 1 released, 0 pressed
  localparam logic [0:30] DIRECTED_LEVELS = 31'b0111011111101011100010101010111;

  click_mode_turnout_restore_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  click_mode_turnout_restore_checker result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_tick(input logic level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, level};
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
  endtask

  // hold off until every outstanding result transaction has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_regs();
    reg_idx_t idx;
    idx = idx.first();
    do begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      case (idx)
        REG_TURNOUT_COUNT: cfg_data <= 32'(cur_cfg.turnout_count);
        REG_HOME_POS:      cfg_data <= cur_cfg.home_positions;
        REG_SAVED_POS:     cfg_data <= cur_cfg.saved_positions;
        REG_STEP_INTERVAL: cfg_data <= 32'(cur_cfg.step_interval);
        REG_MIN_PRESS:     cfg_data <= 32'(cur_cfg.min_press);
        REG_MAX_PRESS:     cfg_data <= 32'(cur_cfg.max_press);
        REG_CLICK_GAP:     cfg_data <= 32'(cur_cfg.click_gap);
        REG_BLINK_PERIOD:  cfg_data <= 32'(cur_cfg.blink_period);
        default:           cfg_data <= '0;
      endcase
      do @(posedge clk); while (!cfg_ready);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_cfg(input logic [5:0] tc, input logic [31:0] home, saved,
                           input logic [15:0] step, input logic [9:0] minp,
                           input logic [11:0] maxp, gap, blink);
    cur_cfg.turnout_count   = tc;
    cur_cfg.home_positions  = home;
    cur_cfg.saved_positions = saved;
    cur_cfg.step_interval   = step;
    cur_cfg.min_press       = minp;
    cur_cfg.max_press       = maxp;
    cur_cfg.click_gap       = gap;
    cur_cfg.blink_period    = blink;
    drain();
    load_regs();
  endtask

  // a click group or random levels: presses often near the length limits, gaps
  // in it, then a quiet stretch that closes it and often lets a restore run out
  task automatic click_burst();
    int minp, maxp, gap, gap_cap, span, presses, len, idle_len, roll;
    minp    = int'(cur_cfg.min_press);
    maxp    = int'(cur_cfg.max_press);
    gap     = int'(cur_cfg.click_gap);
    gap_cap = (gap < 1) ? 1 : gap;
    span    = ((cur_cfg.turnout_count > MAX_TURNOUTS) ? MAX_TURNOUTS
               : int'(cur_cfg.turnout_count)) * (int'(cur_cfg.step_interval) + 1) + 3;
    if (span > 400) span = 400;
    roll = $urandom_range(99);
    if (roll < 10) begin
      repeat ($urandom_range(40, 1)) send_tick(1'($urandom_range(1)));
      return;
    end
    presses = (roll < 45) ? 1 : (roll < 80) ? 2 : $urandom_range(5, 3);
    for (int p = 0; p < presses; p++) begin
      case ($urandom_range(5))
        0:       len = minp;
        1:       len = minp + 1;
        2:       len = maxp - 1;
        3:       len = maxp;
        4:       len = $urandom_range(maxp + 2, 1);
        default: len = $urandom_range((maxp - 1 > minp + 1) ? maxp - 1 : minp + 1, minp + 1);
      endcase
      if (len < 1) len = 1;
      if (len > 1100) len = 1100;
      repeat (len) send_tick(1'b0);
      roll = $urandom_range(9);
      if (p < presses - 1) begin
        if (roll < 7) idle_len = $urandom_range((gap_cap < 8) ? gap_cap : 8, 1);
        else if (roll < 9) idle_len = $urandom_range(gap_cap, 1);
        else idle_len = gap + 1;
      end else begin
        if (roll < 5) idle_len = gap + 1 + $urandom_range(3);
        else if (roll < 8) idle_len = gap + 1 + $urandom_range(span);
        else if (roll < 9) idle_len = gap + 1;
        else idle_len = $urandom_range(gap_cap, 1);
      end
      repeat (idle_len) send_tick(1'b1);
    end
  endtask

  task automatic run_phase(input logic [5:0] tc, input logic [31:0] home, saved,
                           input logic [15:0] step, input logic [9:0] minp,
                           input logic [11:0] maxp, gap, blink,
                           input int n_ticks, idle_pct, stall_pct);
    apply_cfg(tc, home, saved, step, minp, maxp, gap, blink);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    ticks_sent     = 0;
    while (ticks_sent < n_ticks) click_burst();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    apply_cfg(6'd3, 32'h5, 32'h2, 16'd0, 10'd0, 12'd3, 12'd1, 12'd0);
    for (int i = 0; i < $bits(DIRECTED_LEVELS); i++) send_tick(DIRECTED_LEVELS[i]);

    run_phase(6'd5,  $urandom, $urandom, 16'd2, 10'd1, 12'd6, 12'd4, 12'd3, 500, 0, 0);
    run_phase(6'd33, $urandom, $urandom, 16'd0, 10'd0, 12'd4, 12'd2, 12'd0, 400, 78, 0);
    run_phase(6'd63, 32'hFFFF_FFFF, 32'h0, 16'd1, 10'd2, 12'd8, 12'd6, 12'd1, 500, 0, 78);
    run_phase(6'd4,  $urandom, $urandom, 16'd0, 10'd0, 12'd3, 12'd0, 12'd5, 300, 8, 8);
    run_phase(6'd32, $urandom, $urandom, 16'd65535, 10'd1023, 12'd4095, 12'd8, 12'd4095,
              100, 0, 0);
    run_phase(6'd2,  32'h0, 32'hFFFF_FFFF, 16'd3, 10'd0, 12'd5, 12'd4095, 12'd2, 100, 8, 8);
    run_phase(6'd1,  $urandom, $urandom, 16'd1, 10'd0, 12'd0, 12'd1, 12'd1, 100, 0, 0);
    run_phase(6'd8,  $urandom, $urandom, 16'd600, 10'd20, 12'd400, 12'd300, 12'd200,
              200, 0, 0);
    run_phase(6'd40, $urandom, $urandom, 16'd2, 10'd1, 12'd5, 12'd3, 12'd2, 400, 8, 8);

    drain();
    @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
